>>> rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap integer set package
// Shared types, codes and defaults for the bitmap integer set block.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

	localparam int unsigned SET_SIZE_DEF = 65536;

	localparam logic REG_RANGE_FIRST = 1'b0;
	localparam logic REG_RANGE_LAST  = 1'b1;

	typedef enum logic [1:0] {
		MODE_TEST = 2'd0,
		MODE_ADD  = 2'd1,
		MODE_DEL  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_RANGE    = 2'd1,
		STATUS_CONFLICT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] element_value;
		logic        list_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        is_match;
		logic [31:0] match_value;
	} out_item_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic check;
		logic decide;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

>>> rtl/bitmap_integer_set_top.sv
// ----------------------------------------------------------------------------
// Bitmap integer set
// Membership bitmap over a configured integer range with add, delete, test.
// ----------------------------------------------------------------------------
// An item is accepted in IDLE, range-checked and read in CHECK, then
// decided and written in DECIDE, which waits for a free result register.
// A new item is taken only in IDLE, after this read-modify-write ends.
// Reset: range and control registers and list state clear at once;
// then a clearing pass writes every bitmap bit to zero, item_ready low.
`default_nettype none

module bitmap_integer_set_top #(
	parameter int unsigned SET_SIZE = bis_pkg::SET_SIZE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [31:0]        cfg_wdata,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire bis_pkg::in_item_t  item,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output bis_pkg::out_item_t      result
);

	bis_pkg::cmd_t  cmd;
	bis_pkg::stat_t stat;

	bis_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	bis_dp #(
		.SET_SIZE (SET_SIZE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

>>> rtl/bis_ram.sv
// ----------------------------------------------------------------------------
// Bitmap integer set RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/bis_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap integer set controller
// Sequences clearing pass, item intake, range check and bit update.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_ready,
	input  wire bis_pkg::stat_t stat,
	output bis_pkg::cmd_t      cmd
);

	bis_pkg::state_t state_q;
	bis_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bis_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		cmd        = '0;
		unique case (state_q)
			bis_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = bis_pkg::ST_IDLE;
				end
			end
			bis_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = bis_pkg::ST_CHECK;
				end
			end
			bis_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = bis_pkg::ST_DECIDE;
			end
			bis_pkg::ST_DECIDE: begin
				if (stat.out_free) begin
					cmd.decide = 1'b1;
					state_d    = bis_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bis_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/bis_dp.sv
// ----------------------------------------------------------------------------
// Bitmap integer set datapath
// Range registers, item register, range check, bitmap RAM and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_dp #(
	parameter int unsigned SET_SIZE = bis_pkg::SET_SIZE_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [31:0]       cfg_wdata,
	input  wire bis_pkg::in_item_t item,
	input  wire bis_pkg::cmd_t     cmd,
	output bis_pkg::stat_t         stat,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output bis_pkg::out_item_t     result
);

	localparam int unsigned AW = $clog2(SET_SIZE);
	localparam logic [32:0] SIZE_W = 33'(SET_SIZE);
	localparam logic [AW-1:0] CLEAR_END = AW'(SET_SIZE - 1);

	logic [31:0]        range_first_q;
	logic [31:0]        range_last_q;
	bis_pkg::in_item_t  item_q;
	logic               hit_q;
	logic [AW-1:0]      off_q;
	logic [AW-1:0]      clear_cnt_q;
	logic               list_done_q;
	logic               result_valid_q;
	bis_pkg::out_item_t result_q;

	logic [31:0]        off;
	logic               hit;
	logic               rd_bit;
	logic               want;
	logic               upd_we;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic               ram_wdata;
	logic               emit;
	logic               list_done_d;
	bis_pkg::out_item_t res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_first_q <= '0;
			range_last_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == bis_pkg::REG_RANGE_FIRST) begin
				range_first_q <= cfg_wdata;
			end else begin
				range_last_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_cnt_q <= '0;
		end else if (cmd.clear) begin
			clear_cnt_q <= clear_cnt_q + AW'(1);
		end
	end

	assign stat.clear_last = (clear_cnt_q == CLEAR_END);
	assign stat.out_free   = !result_valid_q || result_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.check) begin
			hit_q <= hit;
			off_q <= off[AW-1:0];
		end
	end

	assign off = item_q.element_value - range_first_q;
	assign hit = (item_q.element_value >= range_first_q)
		&& (item_q.element_value <= range_last_q)
		&& ({1'b0, off} < SIZE_W);

	assign want   = (item_q.mode == bis_pkg::MODE_ADD);
	assign upd_we = cmd.decide && hit_q && (rd_bit != want)
		&& ((item_q.mode == bis_pkg::MODE_ADD) || (item_q.mode == bis_pkg::MODE_DEL));

	assign ram_we    = cmd.clear || upd_we;
	assign ram_waddr = cmd.clear ? clear_cnt_q : off_q;
	assign ram_wdata = cmd.clear ? 1'b0 : want;

	bis_ram #(
		.WIDTH (1),
		.DEPTH (SET_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.check),
		.raddr (off[AW-1:0]),
		.rdata (rd_bit)
	);

	always_comb begin
		emit        = 1'b0;
		list_done_d = list_done_q;
		res_d       = '0;
		res_d.status = bis_pkg::STATUS_OK;
		case (item_q.mode) inside
			bis_pkg::MODE_TEST: begin
				if (list_done_q) begin
					if (item_q.list_end) begin
						list_done_d = 1'b0;
					end
				end else if (hit_q && rd_bit) begin
					emit              = 1'b1;
					res_d.is_match    = 1'b1;
					res_d.match_value = item_q.element_value;
					list_done_d       = !item_q.list_end;
				end else if (item_q.list_end) begin
					emit = 1'b1;
				end
			end
			bis_pkg::MODE_ADD, bis_pkg::MODE_DEL: begin
				emit = 1'b1;
				if (!hit_q) begin
					res_d.status = bis_pkg::STATUS_RANGE;
				end else if (rd_bit == want) begin
					res_d.status = bis_pkg::STATUS_CONFLICT;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_done_q    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.decide) begin
				list_done_q <= list_done_d;
			end
			if (cmd.decide && emit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && emit) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_decide_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> (!result_valid_q || result_ready))
		else $error("result register overwritten");

	a_rose_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(cmd.decide))
		else $error("result without decision");

	a_done_test: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(list_done_q) |-> $past(item_q.mode == bis_pkg::MODE_TEST && !item_q.list_end))
		else $error("list marked done outside a test");

	a_upd_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !cmd.decide && !cmd.load)
		else $error("item work during clearing pass");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Bitmap integer set testbench
// Drives add, delete, list test and unused-mode items through the valid/ready channels,
// predicts every reply from a shadow copy of the bitmap, the list state and
// the range registers, and checks each reply field by field in order.
// Random gaps and stalls on both sides, a long reply hold-off, and sender
// pauses exercise the flow control across several range settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SET_SIZE     = bis_pkg::SET_SIZE_DEF;
	localparam int unsigned SET_AW       = $clog2(SET_SIZE);
	localparam int unsigned STALL_LIMIT  = 4 * SET_SIZE + 4096;
	localparam logic [1:0]  MODE_IGNORED = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [31:0]        cfg_wdata;
	logic               item_valid;
	logic               item_ready;
	bis_pkg::in_item_t  item;
	logic               result_valid;
	logic               result_ready;
	bis_pkg::out_item_t result;

	bit          shadow_bits [SET_SIZE];
	bit          shadow_list_done;
	logic [31:0] shadow_first;
	logic [31:0] shadow_last;

	bis_pkg::out_item_t reply_q [$];
	int unsigned mismatches;
	int unsigned sent_items;
	int unsigned hold_len;
	bit          calm;

	bitmap_integer_set_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void predict_reply(input bis_pkg::in_item_t it, output bit has,
			output bis_pkg::out_item_t r);
		logic [31:0] off;
		bit          hit;
		bit          want;
		has = 1'b0;
		r = '0;
		off = it.element_value - shadow_first;
		hit = (it.element_value >= shadow_first) && (it.element_value <= shadow_last) &&
			(off < SET_SIZE);
		case (it.mode) inside
			bis_pkg::MODE_TEST: begin
				if (shadow_list_done) begin
					if (it.list_end)
						shadow_list_done = 1'b0;
				end else if (hit && shadow_bits[off[SET_AW-1:0]]) begin
					has = 1'b1;
					r.is_match = 1'b1;
					r.match_value = it.element_value;
					shadow_list_done = !it.list_end;
				end else if (it.list_end) begin
					has = 1'b1;
				end
			end
			bis_pkg::MODE_ADD, bis_pkg::MODE_DEL: begin
				want = (it.mode == bis_pkg::MODE_ADD);
				has = 1'b1;
				if (!hit) begin
					r.status = bis_pkg::STATUS_RANGE;
				end else if (shadow_bits[off[SET_AW-1:0]] == want) begin
					r.status = bis_pkg::STATUS_CONFLICT;
				end else begin
					shadow_bits[off[SET_AW-1:0]] = want;
					r.status = bis_pkg::STATUS_OK;
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin : check_replies
		bis_pkg::out_item_t want;
		bis_pkg::out_item_t got;
		bit                 has;
		if (arst_n && result_valid && result_ready) begin
			got = result;
			if (reply_q.size() == 0) begin
				$error("unexpected reply: status %0d is_match %0d match_value %0h",
					got.status, got.is_match, got.match_value);
				mismatches++;
			end else begin
				want = reply_q.pop_front();
				if (want.status !== got.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					mismatches++;
				end
				if (want.is_match !== got.is_match) begin
					$error("is_match: expected %0d, actual %0d", want.is_match, got.is_match);
					mismatches++;
				end
				if (want.match_value !== got.match_value) begin
					$error("match_value: expected %0h, actual %0h", want.match_value,
						got.match_value);
					mismatches++;
				end
			end
		end
		if (arst_n && item_valid && item_ready) begin
			predict_reply(item, has, want);
			if (has)
				reply_q.push_back(want);
		end
	end

	initial begin : reply_sink
		int unsigned stall_left;
		stall_left = 0;
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				stall_left = calm ? 0 : $urandom_range(0, 15);
			if (hold_len != 0) begin
				hold_len--;
				result_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("bitmap_integer_set_top test failed");
		$finish;
	end

	function automatic logic [31:0] span_end(input logic [31:0] f, input logic [31:0] k);
		span_end = (f > 32'hFFFF_FFFF - k) ? 32'hFFFF_FFFF : f + k;
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] span;
		logic [31:0] win;
		span = shadow_last - shadow_first;
		win = (shadow_last < shadow_first) ? 32'd3 : ((span > 32'd31) ? 32'd31 : span);
		case ($urandom_range(0, 9))
			0: pick_value = $urandom;
			1: pick_value = shadow_first - 32'd1 + $urandom_range(0, 2);
			2: pick_value = shadow_last - 32'd1 + $urandom_range(0, 2);
			3: pick_value = shadow_first + SET_SIZE - 32'd1 + $urandom_range(0, 1);
			default: pick_value = shadow_first + $urandom_range(0, win);
		endcase
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [31:0] value, input logic last);
		int unsigned       gap;
		bis_pkg::in_item_t it;
		gap = calm ? 0 : $urandom_range(0, 15);
		it.mode = op;
		it.element_value = value;
		it.list_end = last;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		if (op != MODE_IGNORED)
			sent_items++;
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (reply_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bis_pkg::REG_RANGE_FIRST)
			shadow_first = val;
		else
			shadow_last = val;
	endtask

	task automatic set_range(input logic [31:0] f, input logic [31:0] l);
		write_reg(bis_pkg::REG_RANGE_FIRST, f);
		write_reg(bis_pkg::REG_RANGE_LAST, l);
	endtask

	task automatic send_test_list(input int unsigned len);
		for (int unsigned k = 0; k < len; k++) begin
			if ($urandom_range(0, 7) == 0)
				send_item($urandom_range(0, 1) ? bis_pkg::MODE_ADD : bis_pkg::MODE_DEL,
					pick_value(), 1'b0);
			send_item(bis_pkg::MODE_TEST, pick_value(), k == len - 1);
		end
	endtask

	task automatic random_op();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35)
			send_item(bis_pkg::MODE_ADD, pick_value(), 1'($urandom_range(0, 1)));
		else if (r < 55)
			send_item(bis_pkg::MODE_DEL, pick_value(), 1'($urandom_range(0, 1)));
		else if (r < 95)
			send_test_list($urandom_range(1, 6));
		else
			send_item(MODE_IGNORED, $urandom, 1'($urandom_range(0, 1)));
	endtask

	task automatic test_directed();
		send_item(bis_pkg::MODE_ADD, 32'd0, 1'b0);
		send_item(bis_pkg::MODE_ADD, 32'd0, 1'b0);
		send_item(bis_pkg::MODE_ADD, 32'd1, 1'b0);
		send_item(bis_pkg::MODE_TEST, 32'd0, 1'b1);
		send_item(bis_pkg::MODE_DEL, 32'd0, 1'b1);
		send_item(bis_pkg::MODE_DEL, 32'd0, 1'b0);
		send_item(bis_pkg::MODE_TEST, 32'd0, 1'b1);
		send_item(MODE_IGNORED, 32'd0, 1'b1);
		send_item(bis_pkg::MODE_ADD, 32'd0, 1'b0);
		settle();
		set_range(32'd100, 32'd99);
		send_item(bis_pkg::MODE_ADD, 32'd100, 1'b0);
		send_item(bis_pkg::MODE_TEST, 32'd100, 1'b1);
		send_item(bis_pkg::MODE_DEL, 32'd99, 1'b0);
		settle();
		set_range(32'hFFFF_FF00, 32'hFFFF_FFFF);
		send_item(bis_pkg::MODE_ADD, 32'hFFFF_FFFF, 1'b0);
		send_item(bis_pkg::MODE_ADD, 32'hFFFF_FF00, 1'b0);
		send_item(bis_pkg::MODE_ADD, 32'hFFFF_FEFF, 1'b0);
		send_item(bis_pkg::MODE_TEST, 32'd5, 1'b0);
		send_item(bis_pkg::MODE_TEST, 32'hFFFF_FFFF, 1'b0);
		send_item(bis_pkg::MODE_TEST, 32'hFFFF_FF00, 1'b0);
		send_item(bis_pkg::MODE_TEST, 32'd7, 1'b1);
		send_item(bis_pkg::MODE_TEST, 32'hFFFF_FF00, 1'b1);
		send_item(bis_pkg::MODE_TEST, 32'd1, 1'b0);
		send_item(bis_pkg::MODE_DEL, 32'hFFFF_FFFF, 1'b0);
		send_item(bis_pkg::MODE_TEST, 32'hFFFF_FFFF, 1'b1);
		settle();
		set_range(32'd0, 32'hFFFF_FFFF);
		send_item(bis_pkg::MODE_ADD, SET_SIZE - 1, 1'b0);
		send_item(bis_pkg::MODE_ADD, SET_SIZE, 1'b0);
		send_item(bis_pkg::MODE_TEST, SET_SIZE, 1'b0);
		send_item(bis_pkg::MODE_TEST, SET_SIZE - 1, 1'b1);
		settle();
	endtask

	task automatic test_random_ranges();
		logic [31:0] f;
		logic [31:0] l;
		int unsigned start;
		for (int p = 0; p < 9; p++) begin
			case (p)
				0: begin
					f = 32'd0;
					l = 32'd0;
				end
				1: begin
					f = 32'hFFFF_FFFF;
					l = 32'hFFFF_FFFF;
				end
				2: begin
					f = 32'd0;
					l = 32'hFFFF_FFFF;
				end
				4, 7: begin
					f = $urandom;
					l = span_end(f, SET_SIZE - 1);
				end
				5: begin
					f = $urandom_range(1, 32'hFFFF_FFFF);
					l = f - 32'd1;
				end
				6: begin
					f = $urandom;
					l = span_end(f, $urandom_range(0, 15));
				end
				default: begin
					f = $urandom;
					l = span_end(f, 63);
				end
			endcase
			calm = (p == 6);
			set_range(f, l);
			start = sent_items;
			while (sent_items - start < 125)
				random_op();
			settle();
		end
		calm = 1'b0;
	endtask

	task automatic test_reply_backpressure();
		hold_len = 300;
		calm = 1'b1;
		for (int k = 0; k < 40; k++)
			send_item(k[0] ? bis_pkg::MODE_ADD : bis_pkg::MODE_TEST, pick_value(), 1'b1);
		while (hold_len != 0) @(posedge clk);
		calm = 1'b0;
		settle();
	endtask

	task automatic test_sender_pause();
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 15; k++)
				random_op();
			settle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bis_pkg::REG_RANGE_FIRST;
		cfg_wdata = '0;
		item_valid = 1'b0;
		item = '0;
		mismatches = 0;
		sent_items = 0;
		hold_len = 0;
		calm = 1'b0;
		shadow_list_done = 1'b0;
		shadow_first = '0;
		shadow_last = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (item_ready !== 1'b1);

		test_directed();
		test_random_ranges();
		test_reply_backpressure();
		test_sender_pause();

		while (reply_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("bitmap_integer_set_top test passed");
		else
			$display("bitmap_integer_set_top test failed");
		$finish;
	end

endmodule

`default_nettype wire
